>>> hdl/euler_motion_integrator_defines.svh
// Assertion macros used by the checker of the motion integrator.
// No dependencies; the user must provide clk and rst_n in scope.
`ifndef EULER_MOTION_INTEGRATOR_DEFINES_SVH
`define EULER_MOTION_INTEGRATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EMI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EMI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/emi_pkg.sv
// Package of the motion integrator: widths, codes, reset values and the
// saturating fixed point helpers. No dependencies.
`timescale 1ns / 1ps

package emi_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int WORD_BITS    = 32;
    localparam int CFG_BITS     = 32;
    localparam int OUT_BITS     = 32;
    localparam int MASS_BITS    = 31;
    localparam int DT_BITS      = 31;
    localparam int VLIM_BITS    = 2 * CFG_BITS;
    localparam int CTRL_BITS    = 4;
    localparam int CMD_BITS     = 2;
    localparam int DIR_BITS     = 2;
    localparam int MODE_BITS    = 2;
    localparam int CFG_IDX_BITS = 3;
    localparam int PROD_BITS    = 2 * WORD_BITS;
    localparam int DIV_RAW_BITS = WORD_BITS + FRAC_BITS;
    localparam int DIV_BITS     = DIV_RAW_BITS + (DIV_RAW_BITS % 2);
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_CYCLES   = DIV_BITS / DIV_STEP_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_CYCLES + 1);

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [WORD_BITS-1:0]        mag_t;
    typedef logic [PROD_BITS-1:0]        prod_t;
    typedef logic [CFG_BITS-1:0]         cfg_t;
    typedef logic signed [OUT_BITS-1:0]  out_t;
    typedef logic [MASS_BITS-1:0]        mass_t;
    typedef logic [DT_BITS-1:0]          dt_t;
    typedef logic [VLIM_BITS-1:0]        vlim_t;
    typedef logic [CTRL_BITS-1:0]        ctrl_t;
    typedef logic [CMD_BITS-1:0]         cmd_t;
    typedef logic [DIR_BITS-1:0]         dir_t;
    typedef logic [MODE_BITS-1:0]        mode_t;
    typedef logic [CFG_IDX_BITS-1:0]     cfg_idx_t;

    typedef struct packed {
        logic  neg;
        prod_t mag;
    } mul_res_t;

    localparam cmd_t CMD_TICK    = 2'd0;
    localparam cmd_t CMD_COLLIDE = 2'd1;
    localparam cmd_t CMD_SET_VEL = 2'd2;
    localparam cmd_t CMD_SET_POS = 2'd3;

    localparam dir_t DIR_NONE = 2'd0;
    localparam dir_t DIR_LOW  = 2'd1;
    localparam dir_t DIR_HIGH = 2'd2;

    localparam mode_t MODE_NONE  = 2'd0;
    localparam mode_t MODE_TRACK = 2'd2;

    localparam cfg_idx_t REG_THRUST    = 3'd0;
    localparam cfg_idx_t REG_DRAG      = 3'd1;
    localparam cfg_idx_t REG_MASS      = 3'd2;
    localparam cfg_idx_t REG_TIME_STEP = 3'd3;
    localparam cfg_idx_t REG_VEL_LIM   = 3'd4;
    localparam cfg_idx_t REG_POS_MIN   = 3'd5;
    localparam cfg_idx_t REG_POS_MAX   = 3'd6;
    localparam cfg_idx_t REG_CONTROL   = 3'd7;

    localparam word_t WMAX    = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WMIN    = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam mag_t  MAG_LIM = mag_t'(1) << (WORD_BITS - 1);

    localparam cfg_t  THRUST_RST = cfg_t'(64'd1 << FRAC_BITS);
    localparam cfg_t  DRAG_RST   = cfg_t'((64'd9 << FRAC_BITS) / 10);
    localparam mass_t MASS_RST   = mass_t'(64'd1 << FRAC_BITS);
    localparam dt_t   DT_RST     = dt_t'(((64'd1 << FRAC_BITS) + 500) / 1000);
    localparam cfg_t  VMAX_RST   = cfg_t'(64'd5 << FRAC_BITS);
    localparam cfg_t  VMIN_RST   = cfg_t'(64'd0 - (64'd5 << FRAC_BITS));
    localparam vlim_t VLIM_RST   = {VMAX_RST, VMIN_RST};
    localparam cfg_t  PMIN_RST   = cfg_t'(64'd0 - (64'd25 << FRAC_BITS));
    localparam cfg_t  PMAX_RST   = cfg_t'(64'd25 << FRAC_BITS);
    localparam ctrl_t CTRL_RST   = '0;
    localparam word_t VEL_RST    = word_t'(64'd1 << FRAC_BITS);

    function automatic word_t to_word(cfg_t x);
        return word_t'(signed'(x));
    endfunction

    function automatic mag_t abs_mag(word_t x);
        return x[WORD_BITS-1] ? mag_t'(-x) : mag_t'(x);
    endfunction

    function automatic word_t sign_mag(logic neg, mag_t m);
        if (m >= MAG_LIM)
            return neg ? WMIN : WMAX;
        return neg ? word_t'(-m) : word_t'(m);
    endfunction

    function automatic mag_t prod_clamp(prod_t p);
        logic [PROD_BITS-FRAC_BITS-1:0] r;
        r = p[PROD_BITS-1:FRAC_BITS];
        if (r[PROD_BITS-FRAC_BITS-1:WORD_BITS-1] != '0)
            return MAG_LIM;
        return r[WORD_BITS-1:0];
    endfunction

    function automatic word_t sat_add(word_t a, word_t b);
        logic [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WMIN : WMAX;
        return word_t'(s[WORD_BITS-1:0]);
    endfunction

    function automatic word_t sat_sub(word_t a, word_t b);
        logic [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WMIN : WMAX;
        return word_t'(s[WORD_BITS-1:0]);
    endfunction

    function automatic word_t sat_neg(word_t x);
        return (x == WMIN) ? WMAX : word_t'(-x);
    endfunction

endpackage

>>> hdl/emi_mul.sv
// Shared sign-magnitude multiplier with a registered product.
// Depends on emi_pkg.
`timescale 1ns / 1ps

module emi_mul (
    input  logic              clk,
    input  emi_pkg::word_t    a,
    input  emi_pkg::word_t    b,
    output emi_pkg::mul_res_t res
);
    import emi_pkg::*;

    mul_res_t res_reg;
    mul_res_t res_next;

    always_comb
    begin
        res_next.neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        res_next.mag = PROD_BITS'(abs_mag(a)) * PROD_BITS'(abs_mag(b));
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

>>> hdl/emi_div.sv
// Restoring divider that forms (dividend << FRAC_BITS) / divisor, two
// quotient bits per cycle, with the quotient clamped to the word range.
// Depends on emi_pkg.
`timescale 1ns / 1ps

module emi_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  emi_pkg::mag_t  dividend,
    input  emi_pkg::mass_t divisor,
    output logic           done,
    output emi_pkg::mag_t  quotient
);
    import emi_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIV_BITS-1:0]     dq_reg, dq_next;
    mass_t                   rem_reg, rem_next;
    mass_t                   dvs_reg, dvs_next;

    always_comb
    begin
        logic [MASS_BITS:0]  trial;
        logic [DIV_BITS-1:0] dq_v;
        mass_t               rem_v;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dq_v      = dq_reg;
        rem_v     = rem_reg;
        trial     = '0;

        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            trial = {rem_v, dq_v[DIV_BITS-1]};
            dq_v  = {dq_v[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial   = trial - {1'b0, dvs_reg};
                dq_v[0] = 1'b1;
            end
            rem_v = trial[MASS_BITS-1:0];
        end

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(DIV_CYCLES);
            dq_next   = DIV_BITS'(dividend) << FRAC_BITS;
            rem_next  = '0;
            dvs_next  = (divisor == '0) ? mass_t'(1) : divisor;
        end
        else if (busy_reg)
        begin
            dq_next  = dq_v;
            rem_next = rem_v;
            cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = (dq_reg[DIV_BITS-1:WORD_BITS-1] != '0) ? MAG_LIM
                                                             : dq_reg[WORD_BITS-1:0];

endmodule

>>> hdl/euler_motion_integrator.sv
// Top level of the one-dimensional semi-implicit Euler motion integrator.
// Depends on emi_pkg, emi_mul and emi_div.
`timescale 1ns / 1ps

// The block holds velocity and position in signed Q16.16 and a collision
// side, and takes one command item at a time. Set commands are taken
// directly and give no result. A tick or collide command runs through a
// small sequencer that drives one shared 32 by 32 multiplier and one
// divider; a bounce test and each bounce that fires add steps to it. The
// 48-bit divide runs at two quotient bits a cycle. A finished result
// waits in an output register, so the next item is taken while it is
// still pending.
module euler_motion_integrator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  emi_pkg::cmd_t        cmd,
    input  logic signed [31:0]   value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output emi_pkg::out_t        velocity_out,
    output emi_pkg::out_t        position_out,
    output emi_pkg::dir_t        direction_out,
    output logic                 velocity_report,
    output logic                 position_report,
    output logic                 direction_report,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  emi_pkg::cfg_idx_t    cfg_index,
    input  emi_pkg::vlim_t       cfg_data
);
    import emi_pkg::*;

    localparam int ST_BITS = 4;
    localparam logic [ST_BITS-1:0] ST_IDLE     = 4'd0;
    localparam logic [ST_BITS-1:0] ST_MUL_DRAG = 4'd1;
    localparam logic [ST_BITS-1:0] ST_F_CALC   = 4'd2;
    localparam logic [ST_BITS-1:0] ST_DIV_WAIT = 4'd3;
    localparam logic [ST_BITS-1:0] ST_MUL_A    = 4'd4;
    localparam logic [ST_BITS-1:0] ST_V_ADD    = 4'd5;
    localparam logic [ST_BITS-1:0] ST_MUL_V    = 4'd6;
    localparam logic [ST_BITS-1:0] ST_S_ADD    = 4'd7;
    localparam logic [ST_BITS-1:0] ST_BND_LO   = 4'd8;
    localparam logic [ST_BITS-1:0] ST_MUL_LO   = 4'd9;
    localparam logic [ST_BITS-1:0] ST_ADD_LO   = 4'd10;
    localparam logic [ST_BITS-1:0] ST_BND_HI   = 4'd11;
    localparam logic [ST_BITS-1:0] ST_MUL_HI   = 4'd12;
    localparam logic [ST_BITS-1:0] ST_ADD_HI   = 4'd13;
    localparam logic [ST_BITS-1:0] ST_FINISH   = 4'd14;

    cfg_t  thrust_reg, drag_reg, pmin_reg, pmax_reg;
    mass_t mass_reg;
    dt_t   dt_reg;
    vlim_t vlim_reg;
    ctrl_t ctrl_reg;

    logic [ST_BITS-1:0] state_reg, state_next;
    word_t vel_reg, vel_next;
    word_t pos_reg, pos_next;
    dir_t  dir_reg, dir_next;
    logic  out_valid_reg, out_valid_next;

    word_t vn_reg, vn_next;
    word_t sn_reg, sn_next;
    word_t acc_reg, acc_next;
    logic  fneg_reg, fneg_next;
    dir_t  dirw_reg, dirw_next;
    cmd_t  cmd_reg, cmd_next;

    out_t  out_vel_reg, out_vel_next;
    out_t  out_pos_reg, out_pos_next;
    dir_t  out_dir_reg, out_dir_next;
    logic  out_vr_reg, out_vr_next;
    logic  out_pr_reg, out_pr_next;
    logic  out_dr_reg, out_dr_next;

    word_t    mul_a, mul_b, mul_val;
    mul_res_t mul_res;
    logic     div_start, div_done;
    mag_t     div_dividend, div_q;

    word_t thrust_w, drag_w, dt_w, vmin_w, vmax_w, pmin_w, pmax_w;
    mode_t mode;
    logic  clip_v, clip_p, track;

    assign thrust_w = to_word(thrust_reg);
    assign drag_w   = to_word(drag_reg);
    assign dt_w     = word_t'(dt_reg);
    assign vmin_w   = to_word(vlim_reg[CFG_BITS-1:0]);
    assign vmax_w   = to_word(vlim_reg[VLIM_BITS-1:CFG_BITS]);
    assign pmin_w   = to_word(pmin_reg);
    assign pmax_w   = to_word(pmax_reg);
    assign clip_v   = ctrl_reg[0];
    assign clip_p   = ctrl_reg[1];
    assign mode     = ctrl_reg[CTRL_BITS-1:CTRL_BITS-MODE_BITS];
    assign track    = (mode >= MODE_TRACK);
    assign mul_val  = sign_mag(mul_res.neg, prod_clamp(mul_res.mag));

    emi_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .res (mul_res)
    );

    emi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (mass_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thrust_reg <= THRUST_RST;
            drag_reg   <= DRAG_RST;
            mass_reg   <= MASS_RST;
            dt_reg     <= DT_RST;
            vlim_reg   <= VLIM_RST;
            pmin_reg   <= PMIN_RST;
            pmax_reg   <= PMAX_RST;
            ctrl_reg   <= CTRL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THRUST:    thrust_reg <= cfg_data[CFG_BITS-1:0];
                REG_DRAG:      drag_reg   <= cfg_data[CFG_BITS-1:0];
                REG_MASS:      mass_reg   <= cfg_data[MASS_BITS-1:0];
                REG_TIME_STEP: dt_reg     <= cfg_data[DT_BITS-1:0];
                REG_VEL_LIM:   vlim_reg   <= cfg_data;
                REG_POS_MIN:   pmin_reg   <= cfg_data[CFG_BITS-1:0];
                REG_POS_MAX:   pmax_reg   <= cfg_data[CFG_BITS-1:0];
                REG_CONTROL:   ctrl_reg   <= cfg_data[CTRL_BITS-1:0];
            endcase
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        word_t f, vn, sn;
        dir_t  dir_fin;
        logic  vr, pr, dr, emit;

        state_next     = state_reg;
        vel_next       = vel_reg;
        pos_next       = pos_reg;
        dir_next       = dir_reg;
        out_valid_next = out_valid_reg && !out_ready;
        vn_next        = vn_reg;
        sn_next        = sn_reg;
        acc_next       = acc_reg;
        fneg_next      = fneg_reg;
        dirw_next      = dirw_reg;
        cmd_next       = cmd_reg;
        out_vel_next   = out_vel_reg;
        out_pos_next   = out_pos_reg;
        out_dir_next   = out_dir_reg;
        out_vr_next    = out_vr_reg;
        out_pr_next    = out_pr_reg;
        out_dr_next    = out_dr_reg;
        mul_a          = vn_reg;
        mul_b          = dt_w;
        div_start      = 1'b0;
        f              = sat_sub(thrust_w, mul_val);
        div_dividend   = abs_mag(f);
        vn             = sat_add(vel_reg, mul_val);
        sn             = sat_add(pos_reg, mul_val);
        dir_fin        = dirw_reg;
        vr             = 1'b0;
        pr             = 1'b0;
        dr             = 1'b0;
        emit           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (cmd)
                        CMD_TICK:
                        begin
                            cmd_next   = cmd;
                            dirw_next  = dir_reg;
                            state_next = ST_MUL_DRAG;
                        end
                        CMD_COLLIDE:
                        begin
                            cmd_next   = cmd;
                            dirw_next  = dir_reg;
                            vel_next   = sat_neg(vel_reg);
                            state_next = ST_MUL_DRAG;
                        end
                        CMD_SET_VEL: vel_next = to_word(value);
                        CMD_SET_POS: pos_next = to_word(value);
                    endcase
                end
            end
            ST_MUL_DRAG:
            begin
                mul_a      = drag_w;
                mul_b      = vel_reg;
                state_next = ST_F_CALC;
            end
            ST_F_CALC:
            begin
                fneg_next  = f[WORD_BITS-1];
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    acc_next   = sign_mag(fneg_reg, div_q);
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                mul_a      = acc_reg;
                state_next = ST_V_ADD;
            end
            ST_V_ADD:
            begin
                if (clip_v)
                begin
                    if (vn < vmin_w)
                        vn = vmin_w;
                    if (vn > vmax_w)
                        vn = vmax_w;
                end
                vn_next    = vn;
                state_next = ST_MUL_V;
            end
            ST_MUL_V:
            begin
                state_next = ST_S_ADD;
            end
            ST_S_ADD:
            begin
                if (clip_p)
                begin
                    if (sn > pmin_w && sn < pmax_w)
                        dirw_next = DIR_NONE;
                    if (sn < pmin_w)
                        sn = pmin_w;
                    if (sn > pmax_w)
                        sn = pmax_w;
                end
                sn_next    = sn;
                state_next = (clip_p && mode != MODE_NONE) ? ST_BND_LO : ST_FINISH;
            end
            ST_BND_LO:
            begin
                if (sn_reg <= pmin_w)
                begin
                    vn_next = sat_neg(vn_reg);
                    if (track)
                        dirw_next = DIR_LOW;
                    state_next = ST_MUL_LO;
                end
                else
                begin
                    state_next = ST_BND_HI;
                end
            end
            ST_MUL_LO:
            begin
                state_next = ST_ADD_LO;
            end
            ST_ADD_LO:
            begin
                sn_next    = sat_add(sn_reg, mul_val);
                state_next = ST_BND_HI;
            end
            ST_BND_HI:
            begin
                if (sn_reg >= pmax_w)
                begin
                    vn_next = sat_neg(vn_reg);
                    if (track)
                        dirw_next = DIR_HIGH;
                    state_next = ST_MUL_HI;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL_HI:
            begin
                state_next = ST_ADD_HI;
            end
            ST_ADD_HI:
            begin
                sn_next    = sat_add(sn_reg, mul_val);
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (cmd_reg == CMD_COLLIDE)
                    begin
                        if (track)
                        begin
                            if (vn_reg > 0)
                                dir_fin = DIR_LOW;
                            else if (vn_reg < 0)
                                dir_fin = DIR_HIGH;
                            else
                                dir_fin = DIR_NONE;
                        end
                        vr   = 1'b1;
                        pr   = 1'b1;
                        dr   = track;
                        emit = 1'b1;
                    end
                    else
                    begin
                        vr   = (vn_reg != vel_reg);
                        pr   = (sn_reg != pos_reg);
                        dr   = track && (dirw_reg != dir_reg);
                        emit = vr || pr || dr;
                    end
                    vel_next   = vn_reg;
                    pos_next   = sn_reg;
                    dir_next   = dir_fin;
                    state_next = ST_IDLE;
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        out_vel_next   = out_t'(vn_reg);
                        out_pos_next   = out_t'(sn_reg);
                        out_dir_next   = dir_fin;
                        out_vr_next    = vr;
                        out_pr_next    = pr;
                        out_dr_next    = dr;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vel_reg       <= VEL_RST;
            pos_reg       <= '0;
            dir_reg       <= DIR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vel_reg       <= vel_next;
            pos_reg       <= pos_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vn_reg      <= vn_next;
        sn_reg      <= sn_next;
        acc_reg     <= acc_next;
        fneg_reg    <= fneg_next;
        dirw_reg    <= dirw_next;
        cmd_reg     <= cmd_next;
        out_vel_reg <= out_vel_next;
        out_pos_reg <= out_pos_next;
        out_dir_reg <= out_dir_next;
        out_vr_reg  <= out_vr_next;
        out_pr_reg  <= out_pr_next;
        out_dr_reg  <= out_dr_next;
    end

    assign out_valid        = out_valid_reg;
    assign velocity_out     = out_vel_reg;
    assign position_out     = out_pos_reg;
    assign direction_out    = out_dir_reg;
    assign velocity_report  = out_vr_reg;
    assign position_report  = out_pr_reg;
    assign direction_report = out_dr_reg;

endmodule

>>> hdl/emi_checker.sv
// Port-level checker for the motion integrator, bound to the top level.
// Depends on emi_pkg and euler_motion_integrator_defines.svh.
`timescale 1ns / 1ps
`include "euler_motion_integrator_defines.svh"

module emi_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input emi_pkg::cmd_t        cmd,
    input logic                 out_valid,
    input logic                 out_ready,
    input emi_pkg::out_t        velocity_out,
    input emi_pkg::out_t        position_out,
    input emi_pkg::dir_t        direction_out,
    input logic                 velocity_report,
    input logic                 position_report,
    input logic                 direction_report
);
    import emi_pkg::*;

    logic                            out_stall;
    logic                            set_acc;
    logic                            step_acc;
    logic [2*OUT_BITS+DIR_BITS-1:0]  out_data;
    logic [2:0]                      out_rep;

    assign out_stall = out_valid && !out_ready;
    assign set_acc   = in_valid && in_ready && (cmd == CMD_SET_VEL || cmd == CMD_SET_POS);
    assign step_acc  = in_valid && in_ready && (cmd == CMD_TICK || cmd == CMD_COLLIDE);
    assign out_data  = {velocity_out, position_out, direction_out};
    assign out_rep   = {velocity_report, position_report, direction_report};

    // A result that is not taken keeps its values.
    `EMI_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "stalled result changed")

    // Every result reports at least one value.
    `EMI_ASSERT_NOW(a_report_any, out_valid, |out_rep, "result without any report bit")

    // A set command never produces a result.
    `EMI_ASSERT_NEXT(a_set_quiet, set_acc && !out_valid, !out_valid, "set command produced a result")

    // A tick or collide item keeps the block busy in the next cycle.
    `EMI_ASSERT_NEXT(a_busy_after_step, step_acc, !in_ready, "block ready right after a step item")

endmodule

bind euler_motion_integrator emi_checker u_emi_checker (.*);
